// ----- sv/c2c_pkg.sv -----
package c2c_pkg;

   localparam int MaxRows    = 1024;
   localparam int MaxCols    = 1024;
   localparam int MaxEntries = 4096;
   localparam int ValueBits  = 64;

   localparam int RowW      = 10;
   localparam int ColW      = 10;
   localparam int IdxW      = 13;
   localparam int RegW      = 11;
   localparam int CntW      = 13;
   localparam int PosW      = 14;
   localparam int CntAddrW  = $clog2(MaxRows);
   localparam int PtrAddrW  = $clog2(MaxRows + 1);
   localparam int EntAddrW  = $clog2(MaxEntries);
   localparam int CsrIdxW   = 2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_ROW  = 2'd1;
   localparam logic [1:0] STAT_COL  = 2'd2;
   localparam logic [1:0] STAT_FULL = 2'd3;

   localparam logic [CsrIdxW-1:0] REG_NUM_ROWS = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_NUM_COLS = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_VALUES   = 2'd2;

   typedef enum logic [1:0] {
      KIND_ACK   = 2'd0,
      KIND_PTR   = 2'd1,
      KIND_ENTRY = 2'd2,
      KIND_DONE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic                 cmd;
      logic [1:0]           status;
      logic [RowW-1:0]      row;
      logic [ColW-1:0]      col;
      logic [ValueBits-1:0] value;
   } item_type;

   typedef struct packed {
      logic [RowW-1:0]      row;
      logic [ColW-1:0]      col;
      logic [ValueBits-1:0] value;
   } ent_type;

   typedef struct packed {
      logic [RegW-1:0] rows;
      logic            values_present;
   } cfg_type;

   // true if a sorts after b: row, then column, then signed value
   function automatic logic sorts_after(ent_type a, ent_type b);
      logic res;
      if (a.row != b.row) begin
         res = a.row > b.row;
      end else if (a.col != b.col) begin
         res = a.col > b.col;
      end else begin
         res = $signed(a.value) > $signed(b.value);
      end
      return res;
   endfunction

endpackage

// ----- sv/c2c_front.sv -----
module c2c_front
   import c2c_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_command,
   input  logic [RowW-1:0]             req_row,
   input  logic [ColW-1:0]             req_col,
   input  logic signed [ValueBits-1:0] req_value,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CsrIdxW-1:0]          csr_index,
   input  logic [RegW-1:0]             csr_data,
   input  logic                        q_full,
   input  logic                        hold,
   output logic                        push,
   output item_type                    push_item,
   output cfg_type                     cfg
);

   logic [RegW-1:0] num_rows_ff, num_rows_in;
   logic [RegW-1:0] num_cols_ff, num_cols_in;
   logic            vp_ff, vp_in;
   logic [RegW-1:0] rows_c, cols_c;

   assign csr_ready = 1'b1;

   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      vp_in       = vp_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_NUM_ROWS: num_rows_in = csr_data;
            REG_NUM_COLS: num_cols_in = csr_data;
            REG_VALUES:   vp_in       = csr_data[0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= RegW'(MaxRows);
         num_cols_ff <= RegW'(MaxCols);
         vp_ff       <= 1'b1;
      end else begin
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
         vp_ff       <= vp_in;
      end
   end

   // saturate into 1..max
   always_comb begin
      if (num_rows_ff == '0) rows_c = RegW'(1);
      else if (num_rows_ff > RegW'(MaxRows)) rows_c = RegW'(MaxRows);
      else rows_c = num_rows_ff;
      if (num_cols_ff == '0) cols_c = RegW'(1);
      else if (num_cols_ff > RegW'(MaxCols)) cols_c = RegW'(MaxCols);
      else cols_c = num_cols_ff;
   end

   assign cfg.rows           = rows_c;
   assign cfg.values_present = vp_ff;

   always_comb begin
      push_item.cmd   = req_command;
      push_item.row   = req_row;
      push_item.col   = req_col;
      push_item.value = vp_ff ? req_value : '0;
      if (RegW'(req_row) >= rows_c) push_item.status = STAT_ROW;
      else if (RegW'(req_col) >= cols_c) push_item.status = STAT_COL;
      else push_item.status = STAT_OK;
   end

   assign req_stall = q_full || hold;
   assign push      = req_valid && !req_stall;

endmodule

// ----- sv/c2c_queue.sv -----
module c2c_queue
   import c2c_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     empty,
   output item_type head
);

   item_type   slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
   end

endmodule

// ----- sv/c2c_back.sv -----
module c2c_back
   import c2c_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  item_type                    q_head,
   output logic                        pop,
   input  cfg_type                     cfg,
   output logic                        clearing,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_kind,
   output logic [IdxW-1:0]             rsp_out_index,
   output logic signed [ValueBits-1:0] rsp_out_value,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_last
);

   typedef enum logic [13:0] {
      ST_CLEAR   = 14'b00000000000001,
      ST_IDLE    = 14'b00000000000010,
      ST_LOAD_WR = 14'b00000000000100,
      ST_PFX_RD  = 14'b00000000001000,
      ST_PFX_WR  = 14'b00000000010000,
      ST_SC_RD   = 14'b00000000100000,
      ST_SC_CUR  = 14'b00000001000000,
      ST_SC_WR   = 14'b00000010000000,
      ST_SO_RD   = 14'b00000100000000,
      ST_SO_HOLD = 14'b00001000000000,
      ST_SO_CMP  = 14'b00010000000000,
      ST_SO_PUT  = 14'b00100000000000,
      ST_EMIT_RD = 14'b01000000000000,
      ST_EMIT_OUT= 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   logic                phase_ff, phase_in;
   logic [1:0]          err_ff, err_in;
   logic [CntW-1:0]     total_ff, total_in;
   logic [PosW-1:0]     pos_ff, pos_in;
   logic [RegW-1:0]     built_ff, built_in;
   logic [CntW-1:0]     nnz_ff, nnz_in;
   logic [CntAddrW-1:0] clr_ff, clr_in;
   logic [RegW-1:0]     r_ff, r_in;
   logic [CntW-1:0]     acc_ff, acc_in;
   logic [CntW-1:0]     k_ff, k_in;
   logic [EntAddrW-1:0] i_ff, i_in;
   logic [EntAddrW-1:0] j_ff, j_in;
   ent_type             x_ff, x_in;
   logic [RowW-1:0]     ld_row_ff, ld_row_in;
   kind_type            em_kind_ff, em_kind_in;

   logic                rsp_valid_ff;
   logic [1:0]          kind_ff;
   logic [IdxW-1:0]     idx_ff;
   logic [ValueBits-1:0] val_ff;
   logic [1:0]          status_ff;
   logic                last_ff;

   logic                out_load;
   kind_type            o_kind;
   logic [IdxW-1:0]     o_idx;
   logic [ValueBits-1:0] o_val;
   logic [1:0]          o_stat;
   logic                o_last;
   logic                out_free;

   // row count memory, doubles as the fill cursor during the build
   logic [CntW-1:0]     cnt_mem [MaxRows];
   logic                cnt_we;
   logic [CntAddrW-1:0] cnt_waddr, cnt_raddr;
   logic [CntW-1:0]     cnt_wdata, cnt_rd_ff;

   logic [IdxW-1:0]     ptr_mem [MaxRows+1];
   logic                ptr_we;
   logic [PtrAddrW-1:0] ptr_waddr, ptr_raddr;
   logic [IdxW-1:0]     ptr_wdata, ptr_rd_ff;

   ent_type             ent_mem [MaxEntries];
   logic                ent_we;
   ent_type             ent_wdata, ent_rd_ff;

   ent_type             srt_mem [MaxEntries];
   logic                srt_we;
   logic [EntAddrW-1:0] srt_waddr, srt_raddr;
   ent_type             srt_wdata, srt_rd_ff;

   logic [1:0]          ld_stat;
   logic [PosW-1:0]     ent_off;
   logic                is_ptr, is_ent;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign clearing  = state_ff == ST_CLEAR;

   assign ent_off = pos_ff - PosW'(built_ff) - PosW'(1);
   assign is_ptr  = pos_ff <= PosW'(built_ff);
   assign is_ent  = ent_off < PosW'(nnz_ff);

   assign ent_wdata.row   = q_head.row;
   assign ent_wdata.col   = q_head.col;
   assign ent_wdata.value = q_head.value;

   always_comb begin
      if (q_head.status != STAT_OK) ld_stat = q_head.status;
      else if (total_ff >= CntW'(MaxEntries)) ld_stat = STAT_FULL;
      else ld_stat = STAT_OK;
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      err_in     = err_ff;
      total_in   = total_ff;
      pos_in     = pos_ff;
      built_in   = built_ff;
      nnz_in     = nnz_ff;
      clr_in     = clr_ff;
      r_in       = r_ff;
      acc_in     = acc_ff;
      k_in       = k_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      x_in       = x_ff;
      ld_row_in  = ld_row_ff;
      em_kind_in = em_kind_ff;
      pop        = 1'b0;
      out_load   = 1'b0;
      o_kind     = KIND_ACK;
      o_idx      = '0;
      o_val      = '0;
      o_stat     = STAT_OK;
      o_last     = 1'b0;
      cnt_we     = 1'b0;
      cnt_waddr  = ld_row_ff;
      cnt_wdata  = cnt_rd_ff + CntW'(1);
      cnt_raddr  = r_ff[CntAddrW-1:0];
      ptr_we     = 1'b0;
      ptr_waddr  = r_ff;
      ptr_wdata  = acc_ff;
      ptr_raddr  = pos_ff[PtrAddrW-1:0];
      ent_we     = 1'b0;
      srt_we     = 1'b0;
      srt_waddr  = j_ff;
      srt_wdata  = x_ff;
      srt_raddr  = i_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
            clr_in    = clr_ff + CntAddrW'(1);
            if (clr_ff == CntAddrW'(MaxRows - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cnt_raddr = q_head.row;
            if (!q_empty && out_free) begin
               pop = 1'b1;
               if (q_head.cmd == CMD_LOAD) begin
                  out_load = 1'b1;
                  if (!phase_ff) begin
                     o_stat = ld_stat;
                     if (ld_stat != STAT_OK) begin
                        if (err_ff == STAT_OK) err_in = ld_stat;
                     end else begin
                        ent_we    = 1'b1;
                        total_in  = total_ff + CntW'(1);
                        ld_row_in = q_head.row;
                        state_in  = ST_LOAD_WR;
                     end
                  end
               end else begin
                  state_in = ST_EMIT_RD;
                  if (!phase_ff) begin
                     phase_in = 1'b1;
                     pos_in   = '0;
                     if (err_ff == STAT_OK) begin
                        built_in = cfg.rows;
                        r_in     = '0;
                        acc_in   = '0;
                        state_in = ST_PFX_RD;
                     end
                  end
               end
            end
         end
         ST_LOAD_WR: begin
            cnt_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_PFX_RD: begin
            if (r_ff == built_ff) begin
               ptr_we   = 1'b1;
               nnz_in   = acc_ff;
               k_in     = '0;
               state_in = ST_SC_RD;
            end else begin
               state_in = ST_PFX_WR;
            end
         end
         ST_PFX_WR: begin
            ptr_we    = 1'b1;
            cnt_we    = 1'b1;
            cnt_waddr = r_ff[CntAddrW-1:0];
            cnt_wdata = acc_ff;
            acc_in    = acc_ff + cnt_rd_ff;
            r_in      = r_ff + RegW'(1);
            state_in  = ST_PFX_RD;
         end
         ST_SC_RD: begin
            if (k_ff == total_ff) begin
               i_in     = EntAddrW'(1);
               state_in = (nnz_ff > CntW'(1)) ? ST_SO_RD : ST_EMIT_RD;
            end else begin
               state_in = ST_SC_CUR;
            end
         end
         ST_SC_CUR: begin
            // drop entries beyond the latched row count
            if (RegW'(ent_rd_ff.row) >= built_ff) begin
               k_in     = k_ff + CntW'(1);
               state_in = ST_SC_RD;
            end else begin
               cnt_raddr = ent_rd_ff.row;
               state_in  = ST_SC_WR;
            end
         end
         ST_SC_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = ent_rd_ff.row;
            srt_we    = 1'b1;
            srt_waddr = cnt_rd_ff[EntAddrW-1:0];
            srt_wdata = ent_rd_ff;
            k_in      = k_ff + CntW'(1);
            state_in  = ST_SC_RD;
         end
         ST_SO_RD: begin
            state_in = ST_SO_HOLD;
         end
         ST_SO_HOLD: begin
            x_in      = srt_rd_ff;
            j_in      = i_ff;
            srt_raddr = i_ff - EntAddrW'(1);
            state_in  = ST_SO_CMP;
         end
         ST_SO_CMP: begin
            if (sorts_after(srt_rd_ff, x_ff)) begin
               // shift the neighbor up one slot
               srt_we    = 1'b1;
               srt_wdata = srt_rd_ff;
               j_in      = j_ff - EntAddrW'(1);
               if (j_ff != EntAddrW'(1)) srt_raddr = j_ff - EntAddrW'(2);
               else state_in = ST_SO_PUT;
            end else begin
               state_in = ST_SO_PUT;
            end
         end
         ST_SO_PUT: begin
            srt_we = 1'b1;
            if (CntW'(i_ff) + CntW'(1) < nnz_ff) begin
               i_in     = i_ff + EntAddrW'(1);
               state_in = ST_SO_RD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            if (err_ff == STAT_OK && is_ptr) begin
               em_kind_in = KIND_PTR;
               pos_in     = pos_ff + PosW'(1);
               state_in   = ST_EMIT_OUT;
            end else if (err_ff == STAT_OK && is_ent) begin
               srt_raddr  = ent_off[EntAddrW-1:0];
               em_kind_in = KIND_ENTRY;
               pos_in     = pos_ff + PosW'(1);
               state_in   = ST_EMIT_OUT;
            end else begin
               out_load = 1'b1;
               o_kind   = KIND_DONE;
               o_stat   = err_ff;
               o_last   = 1'b1;
               total_in = '0;
               err_in   = STAT_OK;
               pos_in   = '0;
               phase_in = 1'b0;
               clr_in   = '0;
               state_in = ST_CLEAR;
            end
         end
         ST_EMIT_OUT: begin
            out_load = 1'b1;
            o_kind   = em_kind_ff;
            if (em_kind_ff == KIND_PTR) begin
               o_idx = ptr_rd_ff;
            end else begin
               o_idx = IdxW'(srt_rd_ff.col);
               o_val = cfg.values_present ? srt_rd_ff.value : '0;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= 1'b0;
         err_ff       <= STAT_OK;
         total_ff     <= '0;
         pos_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         err_ff       <= err_in;
         total_ff     <= total_in;
         pos_ff       <= pos_in;
         clr_ff       <= clr_in;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      built_ff   <= built_in;
      nnz_ff     <= nnz_in;
      r_ff       <= r_in;
      acc_ff     <= acc_in;
      k_ff       <= k_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      x_ff       <= x_in;
      ld_row_ff  <= ld_row_in;
      em_kind_ff <= em_kind_in;
      if (out_load) begin
         kind_ff   <= o_kind;
         idx_ff    <= o_idx;
         val_ff    <= o_val;
         status_ff <= o_stat;
         last_ff   <= o_last;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (ptr_we) ptr_mem[ptr_waddr] <= ptr_wdata;
      ptr_rd_ff <= ptr_mem[ptr_raddr];
   end

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[total_ff[EntAddrW-1:0]] <= ent_wdata;
      ent_rd_ff <= ent_mem[k_ff[EntAddrW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (srt_we) srt_mem[srt_waddr] <= srt_wdata;
      srt_rd_ff <= srt_mem[srt_raddr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_out_index = idx_ff;
   assign rsp_out_value = val_ff;
   assign rsp_status    = status_ff;
   assign rsp_last      = last_ff;

endmodule

// ----- sv/coo_to_csr_convert_core.sv -----
// COO to CSR converter. Before the first emit item, load items (command 0)
// store one (row, col, value) entry when its status is OK and return an
// acknowledge with that status; later loads are acknowledged with OK status
// and not stored. A stored load does a read-modify-write of the per-row
// count memory. If no error is latched, the first emit item (command 1)
// builds the CSR form before it answers: a prefix sum over the rows in use,
// a scatter of the stored entries and an insertion sort of the entries by
// row, column, then signed value. Each emit item after that streams one
// word from the pointer or sorted-entry memory: row pointers, then (column,
// value) pairs, then a done word with the latched error and last set.
// After reset and after every done word all 1024 rows of the count memory
// are cleared, during which req_stall stays high; configuration writes are
// taken at any time.
module coo_to_csr_convert_core
   import c2c_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_command,
   input  logic [RowW-1:0]             req_row,
   input  logic [ColW-1:0]             req_col,
   input  logic signed [ValueBits-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_kind,
   output logic [IdxW-1:0]             rsp_out_index,
   output logic signed [ValueBits-1:0] rsp_out_value,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CsrIdxW-1:0]          csr_index,
   input  logic [RegW-1:0]             csr_data
);

   logic     q_full, q_empty, push, pop, clearing;
   item_type push_item, q_head;
   cfg_type  cfg;

   c2c_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_value   (req_value),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_full      (q_full),
      .hold        (clearing),
      .push        (push),
      .push_item   (push_item),
      .cfg         (cfg)
   );

   c2c_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   c2c_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .pop           (pop),
      .cfg           (cfg),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_out_index (rsp_out_index),
      .rsp_out_value (rsp_out_value),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule
